// ===== design/nsr_pkg.sv =====
// ----------------------------------------------------------------------------
// nsr_pkg
// Shared types, constants and character classes for the numeric string
// recognizer.
// ----------------------------------------------------------------------------
package nsr_pkg;

    localparam int CHAR_W  = 8;
    localparam int FLAGS_W = 3;
    localparam int CFG_DATA_W = 8;

    // Configuration register indexes
    typedef enum logic {
        CFG_IDX_FLAGS   = 1'b0,
        CFG_IDX_DECIMAL = 1'b1
    } nsr_cfg_idx_t;

    // number_flags bit positions
    localparam int FLAG_NEG_BIT  = 0;
    localparam int FLAG_FRAC_BIT = 1;
    localparam int FLAG_EXP_BIT  = 2;

    localparam logic [FLAGS_W-1:0] FLAGS_RESET   = 3'd7;
    localparam logic [CHAR_W-1:0]  DECIMAL_RESET = 8'd46;

    localparam logic [CHAR_W-1:0] CH_PLUS   = 8'd43;
    localparam logic [CHAR_W-1:0] CH_MINUS  = 8'd45;
    localparam logic [CHAR_W-1:0] CH_EXP_LO = 8'd101;
    localparam logic [CHAR_W-1:0] CH_EXP_UP = 8'd69;
    localparam logic [CHAR_W-1:0] CH_SPACE  = 8'd32;
    localparam logic [CHAR_W-1:0] CH_TAB    = 8'd9;
    localparam logic [CHAR_W-1:0] CH_CR     = 8'd13;
    localparam logic [CHAR_W-1:0] CH_ZERO   = 8'd48;
    localparam logic [CHAR_W-1:0] CH_NINE   = 8'd57;

    typedef enum logic [7:0] {
        PH_LEAD     = 8'b0000_0001,
        PH_INT      = 8'b0000_0010,
        PH_FRAC     = 8'b0000_0100,
        PH_EXP_E    = 8'b0000_1000,
        PH_EXP_SIGN = 8'b0001_0000,
        PH_EXP_DIG  = 8'b0010_0000,
        PH_TRAIL    = 8'b0100_0000,
        PH_BAD      = 8'b1000_0000
    } nsr_phase_t;

    typedef struct packed {
        logic [FLAGS_W-1:0] number_flags;
        logic [CHAR_W-1:0]  decimal_char;
    } nsr_cfg_t;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              last_char;
    } nsr_item_t;

    function automatic logic is_ws(input logic [CHAR_W-1:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic is_dig(input logic [CHAR_W-1:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

endpackage

// ===== design/nsr_in_stage.sv =====
// ----------------------------------------------------------------------------
// nsr_in_stage
// Input register: captures one character beat and holds it until the parser
// consumes it.
// ----------------------------------------------------------------------------
module nsr_in_stage (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  nsr_pkg::nsr_item_t s_item,
    input  logic               advance,
    output logic               item_valid,
    output nsr_pkg::nsr_item_t item
);
    import nsr_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    nsr_item_t item_reg;

    assign s_ready    = !valid_reg || advance;
    assign valid_next = s_ready ? s_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== design/nsr_parser.sv =====
// ----------------------------------------------------------------------------
// nsr_parser
// Parse state machine: advances the phase by one character per step and
// gives the verdict on the final character of a string.
// ----------------------------------------------------------------------------
module nsr_parser (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               step,
    input  nsr_pkg::nsr_item_t item,
    input  nsr_pkg::nsr_cfg_t  cfg,
    output logic               is_number
);
    import nsr_pkg::*;

    nsr_phase_t        phase_reg;
    nsr_phase_t        phase_next;
    logic              digit_seen_reg;
    logic              digit_seen_next;

    nsr_phase_t        phase_new;
    logic              digit_new;
    nsr_phase_t        int_target;
    logic [CHAR_W-1:0] c;
    logic              c_ws;
    logic              c_dig;
    logic              c_exp;

    assign c     = item.char_code;
    assign c_ws  = is_ws(c);
    assign c_dig = is_dig(c);
    assign c_exp = (c == CH_EXP_LO) || (c == CH_EXP_UP);

    // Integer part: digits, then the decimal point, whitespace or end
    always_comb begin
        priority if (c_dig) begin
            int_target = PH_INT;
        end else if ((c == cfg.decimal_char) && cfg.number_flags[FLAG_FRAC_BIT]) begin
            int_target = PH_FRAC;
        end else if (!digit_seen_reg) begin
            int_target = PH_BAD;
        end else if (c_ws) begin
            int_target = PH_TRAIL;
        end else begin
            int_target = PH_BAD;
        end
    end

    always_comb begin
        phase_new = PH_BAD;
        digit_new = digit_seen_reg;
        unique case (phase_reg)
            PH_LEAD: begin
                priority if (c_ws) begin
                    phase_new = PH_LEAD;
                end else if ((c == CH_PLUS) ||
                             ((c == CH_MINUS) && cfg.number_flags[FLAG_NEG_BIT])) begin
                    phase_new = PH_INT;
                end else if (c == CH_MINUS) begin
                    phase_new = PH_BAD;
                end else begin
                    phase_new = int_target;
                    digit_new = digit_seen_reg | c_dig;
                end
            end
            PH_INT: begin
                phase_new = int_target;
                digit_new = digit_seen_reg | c_dig;
            end
            PH_FRAC: begin
                priority if (c_dig) begin
                    phase_new = PH_FRAC;
                    digit_new = 1'b1;
                end else if (!digit_seen_reg) begin
                    phase_new = PH_BAD;
                end else if (cfg.number_flags[FLAG_EXP_BIT] && c_exp) begin
                    phase_new = PH_EXP_E;
                end else if (c_ws) begin
                    phase_new = PH_TRAIL;
                end else begin
                    phase_new = PH_BAD;
                end
            end
            PH_EXP_E: begin
                phase_new = ((c == CH_PLUS) || (c == CH_MINUS)) ? PH_EXP_SIGN : PH_BAD;
            end
            PH_EXP_SIGN: begin
                phase_new = c_dig ? PH_EXP_DIG : PH_BAD;
            end
            PH_EXP_DIG: begin
                phase_new = c_dig ? PH_EXP_DIG : (c_ws ? PH_TRAIL : PH_BAD);
            end
            PH_TRAIL: begin
                phase_new = c_ws ? PH_TRAIL : PH_BAD;
            end
            default: begin
                phase_new = PH_BAD;
            end
        endcase
    end

    // Verdict as seen after this character
    always_comb begin
        unique case (phase_new)
            PH_INT, PH_FRAC:       is_number = digit_new;
            PH_EXP_DIG, PH_TRAIL:  is_number = 1'b1;
            default:               is_number = 1'b0;
        endcase
    end

    // Restart the parse after each final character
    always_comb begin
        phase_next      = phase_reg;
        digit_seen_next = digit_seen_reg;
        if (step) begin
            if (item.last_char) begin
                phase_next      = PH_LEAD;
                digit_seen_next = 1'b0;
            end else begin
                phase_next      = phase_new;
                digit_seen_next = digit_new;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_LEAD;
            digit_seen_reg <= 1'b0;
        end else begin
            phase_reg      <= phase_next;
            digit_seen_reg <= digit_seen_next;
        end
    end

endmodule

// ===== design/numeric_string_recognizer_unit.sv =====
// ----------------------------------------------------------------------------
// numeric_string_recognizer_unit
// Checks a byte stream, one string at a time, for a well-formed number.
// ----------------------------------------------------------------------------
// The block takes one character per cycle and, on the character flagged as
// last, returns one beat telling whether the whole string was a number. A
// character is registered on acceptance, parsed from that register by the
// state machine, and the verdict is registered for output; a final character
// waits in the input register while the output slot is still full. The parse
// state updates once per accepted character, which sets the sustained rate of
// one character per cycle; only a stalled result on output holds up new input.
// Configuration writes (number_flags, decimal_char) take effect on the next
// character and are meant to be made between strings.
module numeric_string_recognizer_unit (
    input  logic                           aclk,
    input  logic                           aresetn,

    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [nsr_pkg::CHAR_W-1:0]     s_char_code,
    input  logic                           s_last_char,

    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_is_number,

    input  logic                           cfg_wr_en,
    input  logic                           cfg_index,
    input  logic [nsr_pkg::CFG_DATA_W-1:0] cfg_wr_data
);
    import nsr_pkg::*;

    nsr_cfg_t  cfg_reg;
    nsr_cfg_t  cfg_next;
    nsr_item_t s_item;
    nsr_item_t item;
    logic      item_valid;
    logic      advance;
    logic      out_free;
    logic      verdict;
    logic      m_valid_reg;
    logic      m_valid_next;
    logic      m_is_number_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (nsr_cfg_idx_t'(cfg_index))
                CFG_IDX_FLAGS:   cfg_next.number_flags = cfg_wr_data[FLAGS_W-1:0];
                CFG_IDX_DECIMAL: cfg_next.decimal_char = cfg_wr_data[CHAR_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.number_flags <= FLAGS_RESET;
            cfg_reg.decimal_char <= DECIMAL_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign s_item = {s_char_code, s_last_char};

    // Non-final characters never wait; a final one needs the output slot
    assign out_free = !m_valid_reg || m_ready;
    assign advance  = item_valid && (!item.last_char || out_free);

    nsr_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    nsr_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance),
        .item      (item),
        .cfg       (cfg_reg),
        .is_number (verdict)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (advance && item.last_char) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && item.last_char) begin
            m_is_number_reg <= verdict;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_is_number = m_is_number_reg;

endmodule

// ===== tb/sv/tb_numeric_string_recognizer_unit.sv =====
// ----------------------------------------------------------------------------
// tb_numeric_string_recognizer_unit
// Self-checking bench for the numeric string recognizer. Strings are fed one
// character per beat, and each verdict beat is compared against a predictor of
// the parse rules, across several number_flags / decimal_char settings.
// ----------------------------------------------------------------------------
module tb_numeric_string_recognizer_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import nsr_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int          RANDOM_CHARS  = 1350;
    localparam int          NUM_PHASES    = 12;
    localparam int          DRAIN_CYCLES  = 4;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;

    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [CHAR_W-1:0]     s_char_code = '0;
    logic                  s_last_char = 1'b0;

    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic                  m_is_number;

    logic                  cfg_wr_en = 1'b0;
    nsr_cfg_idx_t          cfg_index = CFG_IDX_FLAGS;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;

    numeric_string_recognizer_unit uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_char_code (s_char_code),
        .s_last_char (s_last_char),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_is_number (m_is_number),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Stimulus and expectations
    nsr_item_t         char_q[$];
    bit                verdict_q[$];
    logic [CHAR_W-1:0] str_buf[$];
    bit                hold_off = 1'b1;
    int                chars_queued = 0;
    int unsigned       mismatch_count = 0;
    int unsigned       cycle_count = 0;

    // Predictor state and its copy of the registers
    nsr_phase_t         prs_phase = PH_LEAD;
    bit                 prs_digit = 1'b0;
    logic [FLAGS_W-1:0] prs_flags = FLAGS_RESET;
    logic [CHAR_W-1:0]  prs_point = DECIMAL_RESET;

    function automatic bit is_blank(input logic [CHAR_W-1:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic bit is_digit_char(input logic [CHAR_W-1:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // Integer part, or the first byte after a sign / leading blanks
    function automatic nsr_phase_t mantissa_step(input logic [CHAR_W-1:0] c);
        if (is_digit_char(c)) begin
            prs_digit = 1'b1;
            return PH_INT;
        end
        if (c == prs_point && prs_flags[FLAG_FRAC_BIT])
            return PH_FRAC;
        if (!prs_digit)
            return PH_BAD;
        return is_blank(c) ? PH_TRAIL : PH_BAD;
    endfunction

    // Advance the parse by one character; returns 1 when a verdict is due
    function automatic bit predict_char(input logic [CHAR_W-1:0] c, input logic last,
                                        output bit verdict);
        nsr_phase_t nxt;
        verdict = 1'b0;
        case (prs_phase)
            PH_LEAD: begin
                if (is_blank(c))
                    nxt = PH_LEAD;
                else if (c == CH_PLUS || (c == CH_MINUS && prs_flags[FLAG_NEG_BIT]))
                    nxt = PH_INT;
                else if (c == CH_MINUS)
                    nxt = PH_BAD;
                else
                    nxt = mantissa_step(c);
            end
            PH_INT: nxt = mantissa_step(c);
            PH_FRAC: begin
                if (is_digit_char(c)) begin
                    prs_digit = 1'b1;
                    nxt = PH_FRAC;
                end else if (!prs_digit)
                    nxt = PH_BAD;
                else if (prs_flags[FLAG_EXP_BIT] && (c == CH_EXP_LO || c == CH_EXP_UP))
                    nxt = PH_EXP_E;
                else
                    nxt = is_blank(c) ? PH_TRAIL : PH_BAD;
            end
            PH_EXP_E:    nxt = (c == CH_PLUS || c == CH_MINUS) ? PH_EXP_SIGN : PH_BAD;
            PH_EXP_SIGN: nxt = is_digit_char(c) ? PH_EXP_DIG : PH_BAD;
            PH_EXP_DIG: begin
                if (is_digit_char(c))
                    nxt = PH_EXP_DIG;
                else
                    nxt = is_blank(c) ? PH_TRAIL : PH_BAD;
            end
            PH_TRAIL: nxt = is_blank(c) ? PH_TRAIL : PH_BAD;
            default:  nxt = PH_BAD;
        endcase
        prs_phase = nxt;
        if (!last)
            return 1'b0;
        case (nxt)
            PH_INT, PH_FRAC:      verdict = prs_digit;
            PH_EXP_DIG, PH_TRAIL: verdict = 1'b1;
            default:              verdict = 1'b0;
        endcase
        prs_phase = PH_LEAD;
        prs_digit = 1'b0;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // String building
    // ------------------------------------------------------------------
    function automatic logic [CHAR_W-1:0] pick_blank();
        return ($urandom_range(0, 2) == 0) ? CH_SPACE : CHAR_W'($urandom_range(9, 13));
    endfunction

    function automatic logic [CHAR_W-1:0] pick_digit();
        return CH_ZERO + CHAR_W'($urandom_range(0, 9));
    endfunction

    function automatic logic [CHAR_W-1:0] pick_tricky();
        case ($urandom_range(0, 7))
            0:       return CH_PLUS;
            1:       return CH_MINUS;
            2:       return CH_EXP_LO;
            3:       return CH_EXP_UP;
            4:       return prs_point;
            5:       return pick_blank();
            6:       return pick_digit();
            default: return CHAR_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            str_buf.push_back(s[i]);
    endtask

    // Move the buffer to the send queue; flag the final byte when asked
    task automatic flush_string(input bit mark_last);
        nsr_item_t it;
        for (int i = 0; i < str_buf.size(); i++) begin
            it.char_code = str_buf[i];
            it.last_char = mark_last && (i == str_buf.size() - 1);
            char_q.push_back(it);
        end
        chars_queued += str_buf.size();
        str_buf.delete();
    endtask

    // Number-like string, mostly legal under the current settings, then maybe damage it
    task automatic build_number();
        int n_int;
        int n_frac;
        bit has_point;
        int pos;
        repeat ($urandom_range(0, 2)) str_buf.push_back(pick_blank());
        case ($urandom_range(0, 3))
            0:       str_buf.push_back(CH_PLUS);
            1:       str_buf.push_back(CH_MINUS);
            default: ;
        endcase
        n_int = $urandom_range(0, 4);
        has_point = prs_flags[FLAG_FRAC_BIT] && ($urandom_range(0, 1) == 1);
        n_frac = has_point ? $urandom_range(0, 3) : 0;
        if (n_int + n_frac == 0) begin
            if (has_point)
                n_frac = 1;
            else
                n_int = 1;
        end
        repeat (n_int) str_buf.push_back(pick_digit());
        if (has_point) begin
            str_buf.push_back(prs_point);
            repeat (n_frac) str_buf.push_back(pick_digit());
        end
        if (prs_flags[FLAG_EXP_BIT] &&
            ((has_point && $urandom_range(0, 1) == 1) || $urandom_range(0, 7) == 0)) begin
            str_buf.push_back($urandom_range(0, 1) ? CH_EXP_LO : CH_EXP_UP);
            str_buf.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
            repeat ($urandom_range(1, 3)) str_buf.push_back(pick_digit());
        end
        repeat ($urandom_range(0, 2)) str_buf.push_back(pick_blank());
        if ($urandom_range(0, 3) == 0) begin
            pos = $urandom_range(0, str_buf.size() - 1);
            case ($urandom_range(0, 2))
                0: str_buf[pos] = pick_tricky();
                1: if (str_buf.size() > 1) str_buf = str_buf[0:$urandom_range(0, str_buf.size() - 2)];
                default: str_buf.insert(pos, pick_tricky());
            endcase
        end
        flush_string(1'b1);
    endtask

    task automatic fill_phase(input int n_chars);
        int goal;
        goal = chars_queued + n_chars;
        while (chars_queued < goal) begin
            if ($urandom_range(0, 6) == 0) begin
                repeat ($urandom_range(1, 5)) str_buf.push_back(CHAR_W'($urandom_range(0, 255)));
                flush_string(1'b1);
            end else
                build_number();
        end
    endtask

    // ------------------------------------------------------------------
    // Configuration and phase control
    // ------------------------------------------------------------------
    task automatic write_reg(input nsr_cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        if (idx == CFG_IDX_FLAGS)
            prs_flags = value[FLAGS_W-1:0];
        else
            prs_point = value;
    endtask

    // Wait until the sender is empty and every verdict is in, then hold off
    task automatic drain_and_hold();
        do @(negedge aclk);
        while (char_q.size() != 0 || s_valid || verdict_q.size() != 0);
        @(posedge aclk);
        hold_off <= 1'b1;
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic release_sender();
        @(posedge aclk);
        hold_off <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Driver: one character beat at a time, in bursts with gaps
    // ------------------------------------------------------------------
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge aclk) begin : drive_chars
        nsr_item_t nb;
        bit        fire;
        bit        verdict;
        if (!aresetn) begin
            s_valid     <= 1'b0;
            s_char_code <= '0;
            s_last_char <= 1'b0;
        end else begin
            fire = s_valid && s_ready;
            if (fire && predict_char(s_char_code, s_last_char, verdict))
                verdict_q.push_back(verdict);
            if (!s_valid || fire) begin
                if (gap_left != 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (!hold_off && char_q.size() != 0) begin
                    nb = char_q.pop_front();
                    s_valid     <= 1'b1;
                    s_char_code <= nb.char_code;
                    s_last_char <= nb.last_char;
                    if (burst_left != 0)
                        burst_left--;
                    else begin
                        burst_left = $urandom_range(0, 23);
                        case ($urandom_range(0, 3))
                            0:       gap_left = 0;
                            3:       gap_left = $urandom_range(4, 12);
                            default: gap_left = $urandom_range(1, 3);
                        endcase
                    end
                end else
                    s_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: ready follows a rotating pattern that is reloaded now and then
    // ------------------------------------------------------------------
    logic [15:0] ready_pattern = '1;
    int          pattern_left = 0;

    always @(posedge aclk) begin : stall_receiver
        if (pattern_left == 0) begin
            case ($urandom_range(0, 3))
                0:       ready_pattern = '1;
                1:       ready_pattern = 16'($urandom);
                2:       ready_pattern = 16'($urandom | $urandom);
                default: ready_pattern = 16'($urandom & $urandom) | 16'h0001;
            endcase
            pattern_left = $urandom_range(16, 96);
        end
        pattern_left--;
        ready_pattern = {ready_pattern[14:0], ready_pattern[15]};
        m_ready <= ready_pattern[0];
    end

    // ------------------------------------------------------------------
    // Monitor: compare each verdict beat with the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : check_verdicts
        bit want;
        if (aresetn && m_valid && m_ready) begin
            if (verdict_q.size() == 0) begin
                $display("%0t: unexpected verdict beat, expected none, actual is_number=%0b",
                         $time, m_is_number);
                mismatch_count++;
            end else begin
                want = verdict_q.pop_front();
                if (m_is_number !== want) begin
                    $display("%0t: is_number mismatch, expected %0b, actual %0b",
                             $time, want, m_is_number);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_numeric_string_recognizer_unit: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    logic [FLAGS_W-1:0] phase_flags [NUM_PHASES] =
        '{3'd7, 3'd0, 3'd1, 3'd3, 3'd7, 3'd7, 3'd5, 3'd6, 3'd7, 3'd2, 3'd7, 3'd7};
    logic [CHAR_W-1:0]  phase_point [NUM_PHASES] =
        '{8'd46, 8'd46, 8'd44, 8'd0, 8'd255, 8'd32, 8'd43, 8'd45, 8'd53, 8'd46, 8'd46, 8'd46};

    initial begin : run_test
        logic [FLAGS_W-1:0] flags;
        logic [CHAR_W-1:0]  point;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed strings under the reset settings
        add_text("\t+0.5E-9"); str_buf.push_back(CH_CR); flush_string(1'b1);
        add_text("1e+1");      flush_string(1'b1);   // exponent with no fraction
        add_text(" ");         str_buf.push_back(8'd11); flush_string(1'b1);
        add_text("1.e-");      flush_string(1'b1);   // exponent cut short
        str_buf.push_back(8'd255); flush_string(1'b1);
        str_buf.push_back(8'd0);   flush_string(1'b1);
        add_text("-.");        flush_string(1'b1);   // no digit at all
        str_buf.push_back(8'd10); add_text("9"); str_buf.push_back(8'd12);
        flush_string(1'b1);
        release_sender();

        for (int p = 0; p < NUM_PHASES; p++) begin
            drain_and_hold();
            flags = phase_flags[p];
            point = phase_point[p];
            if (p == NUM_PHASES - 2) begin
                flags = FLAGS_W'($urandom_range(0, 7));
                point = CHAR_W'($urandom_range(0, 255));
            end
            // upper data bits of the flags write are don't-care; toggle them
            write_reg(CFG_IDX_FLAGS, {5'($urandom), flags});
            write_reg(CFG_IDX_DECIMAL, point);
            fill_phase(RANDOM_CHARS / NUM_PHASES);
            // leave a string open so the next settings land mid-string
            if (p != NUM_PHASES - 1 && $urandom_range(0, 1) == 1) begin
                repeat ($urandom_range(1, 3)) str_buf.push_back(pick_tricky());
                flush_string(1'b0);
            end
            release_sender();
        end

        drain_and_hold();
        if (mismatch_count == 0) begin
            $display("tb_numeric_string_recognizer_unit: PASS");
        end else begin
            $display("tb_numeric_string_recognizer_unit: FAIL");
        end
        $finish;
    end

endmodule
